@@ rtl/core/oversampled_pulse_synth_highpass_macros.svh @@
// Assertion macros used by the checker file.
`ifndef OVERSAMPLED_PULSE_SYNTH_HIGHPASS_MACROS_SVH
`define OVERSAMPLED_PULSE_SYNTH_HIGHPASS_MACROS_SVH

// Next-cycle implication, sampled on clk, off during reset.
`define OPSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset.
`define OPSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/opsh_pkg.sv @@
// Shared types and constants of the oversampled pulse synth.
package opsh_pkg;

  localparam int FREQ_W     = 16;
  localparam int DUTY_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int ALPHA_W    = 16;
  localparam int PHASE_W    = 32;
  localparam int STEP_DVD_W = 48;
  localparam int THR_SHIFT  = 31;
  localparam int X_W        = 17;
  localparam int Y_W        = 20;
  localparam int SUM_W      = 21;
  localparam int PROD_W     = 38;
  localparam int GAIN_W     = 39;
  localparam int MAG_W      = 38;
  localparam int GAIN_NUM   = 262136;
  localparam int GAIN_DEN   = 655360;
  localparam int GAIN_NUM_W = 19;
  localparam int ROUND_HALF = 32768;
  localparam int Q16_SHIFT  = 16;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64688;
  localparam logic [0:0]         REG_HIGHPASS_ALPHA = 1'b0;

  localparam logic signed [Y_W-1:0] Y_MAX = 20'sd524287;
  localparam logic signed [Y_W-1:0] Y_MIN = -20'sd524288;
  localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0]   SAMPLE_MIN = 16'h8000;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

@@ rtl/core/opsh_if.sv @@
// Handshake interfaces of the input and result channels.
interface opsh_in_if;
  logic                         valid;
  logic                         ready;
  logic                         active;
  logic [opsh_pkg::FREQ_W-1:0]  tone_freq;
  logic [opsh_pkg::DUTY_W-1:0]  duty_level;

  modport source (output valid, active, tone_freq, duty_level, input ready);
  modport sink   (input valid, active, tone_freq, duty_level, output ready);
endinterface

interface opsh_out_if;
  logic                          valid;
  logic                          ready;
  logic [opsh_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

@@ rtl/core/opsh_sdiv.sv @@
// Bit-serial restoring divider by a constant, one quotient bit per cycle.
module opsh_sdiv #(
  parameter int DVD_W   = 48,
  parameter int DIVISOR = 384000,
  parameter int QUO_W   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DVD_W-1:0]      dividend,
  output opsh_pkg::div_stat_t   stat,
  output logic [QUO_W-1:0]      quotient
);
  import opsh_pkg::*;

  localparam int DSR_W = $clog2(DIVISOR + 1);
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [DSR_W:0] DSR = (DSR_W + 1)'(DIVISOR);

  logic             busy_r, done_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r;
  logic [DSR_W:0]   trial, diff;
  logic             qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - DSR;
    qbit    = (trial >= DSR);
    rem_nxt = qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], qbit};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quotient  = quo_r;

endmodule

@@ rtl/core/opsh_osc.sv @@
// Oversampled pulse oscillator: phase accumulator and duty counter.
module opsh_osc #(
  parameter int LEVEL_MAX         = 255,
  parameter int OVERSAMPLE_FACTOR = 8,
  parameter int SAMPLE_RATE       = 48000,
  parameter int CNT_W             = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         active,
  input  logic [opsh_pkg::FREQ_W-1:0]  tone_freq,
  input  logic [opsh_pkg::DUTY_W-1:0]  duty_level,
  output logic                         done,
  output logic [CNT_W-1:0]             count
);
  import opsh_pkg::*;

  localparam int STEP_DIV = SAMPLE_RATE * OVERSAMPLE_FACTOR;
  localparam int PAD_W    = STEP_DVD_W - DUTY_W - THR_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_STEP} state_t;

  state_t             state_r;
  logic               done_r;
  logic [CNT_W-1:0]   count_r, sub_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] step_q, thr_q;
  div_stat_t          step_stat, thr_stat;
  logic               div_start, hit;

  assign div_start = start && active;

  opsh_sdiv #(
    .DVD_W   (STEP_DVD_W),
    .DIVISOR (STEP_DIV),
    .QUO_W   (PHASE_W)
  ) u_step_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({tone_freq, {PHASE_W{1'b0}}}),
    .stat     (step_stat),
    .quotient (step_q)
  );

  opsh_sdiv #(
    .DVD_W   (STEP_DVD_W),
    .DIVISOR (LEVEL_MAX),
    .QUO_W   (PHASE_W)
  ) u_thr_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{PAD_W{1'b0}}, duty_level, {THR_SHIFT{1'b0}}}),
    .stat     (thr_stat),
    .quotient (thr_q)
  );

  always_comb begin
    phase_nxt = phase_r + step_q;
    hit       = thr_stat.ovf || (phase_nxt < thr_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      count_r <= '0;
      sub_r   <= '0;
      phase_r <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            count_r <= '0;
            sub_r   <= '0;
            if (active) begin
              state_r <= S_DIV;
            end else begin
              done_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (step_stat.done) begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          phase_r <= phase_nxt;
          count_r <= count_r + CNT_W'(hit);
          sub_r   <= sub_r + 1'b1;
          if (sub_r == CNT_W'(OVERSAMPLE_FACTOR - 1)) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign count = count_r;

endmodule

@@ rtl/core/opsh_hpf.sv @@
// One-pole DC-blocking high-pass with output gain and saturation.
module opsh_hpf #(
  parameter int OVERSAMPLE_FACTOR = 8,
  parameter int CNT_W             = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [CNT_W-1:0]              count,
  input  logic [opsh_pkg::ALPHA_W-1:0]  alpha,
  output logic                          done,
  output logic [opsh_pkg::SAMPLE_W-1:0] sample
);
  import opsh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_FILT, S_GAIN, S_DSTART, S_DWAIT} state_t;

  state_t                    state_r;
  logic                      done_r;
  logic [SAMPLE_W-1:0]       sample_r;
  logic [X_W-1:0]            x, prev_x_r;
  logic signed [Y_W-1:0]     y_r;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [PROD_W-1:0]  prod_r, rnd;
  logic signed [PROD_W-17:0] t;
  logic signed [Y_W-1:0]     y_nxt;
  logic signed [Y_W+GAIN_NUM_W:0] g_full;
  logic signed [GAIN_W-1:0]  g_r, g_neg;
  logic [MAG_W-1:0]          mag;
  logic                      neg_r;
  logic                      div_start;
  div_stat_t                 div_stat;
  logic [SAMPLE_W-1:0]       quo, sample_nxt;

  always_comb begin
    x = '0;
    for (int i = 0; i <= OVERSAMPLE_FACTOR; i++) begin
      if (count == CNT_W'(i)) begin
        x = X_W'((i * 65536) / OVERSAMPLE_FACTOR);
      end
    end
    sum_nxt = $signed({y_r[Y_W-1], y_r}) + $signed({4'b0, x}) - $signed({4'b0, prev_x_r});
    rnd     = prod_r + PROD_W'(ROUND_HALF);
    t       = rnd[PROD_W-1:Q16_SHIFT];
    priority if (t > $signed({{2{Y_MAX[Y_W-1]}}, Y_MAX})) begin
      y_nxt = Y_MAX;
    end else if (t < $signed({{2{Y_MIN[Y_W-1]}}, Y_MIN})) begin
      y_nxt = Y_MIN;
    end else begin
      y_nxt = t[Y_W-1:0];
    end
    g_full    = y_r * $signed({1'b0, GAIN_NUM_W'(GAIN_NUM)});
    g_neg     = -g_r;
    mag       = g_r[GAIN_W-1] ? g_neg[MAG_W-1:0] : g_r[MAG_W-1:0];
    div_start = (state_r == S_DSTART);
    if (neg_r) begin
      if (div_stat.ovf || (quo[SAMPLE_W-1] && (quo[SAMPLE_W-2:0] != '0))) begin
        sample_nxt = SAMPLE_MIN;
      end else begin
        sample_nxt = -quo;
      end
    end else begin
      if (div_stat.ovf || quo[SAMPLE_W-1]) begin
        sample_nxt = SAMPLE_MAX;
      end else begin
        sample_nxt = quo;
      end
    end
  end

  opsh_sdiv #(
    .DVD_W   (MAG_W),
    .DIVISOR (GAIN_DEN),
    .QUO_W   (SAMPLE_W)
  ) u_gain_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .stat     (div_stat),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      done_r   <= 1'b0;
      prev_x_r <= '0;
      y_r      <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            sum_r    <= sum_nxt;
            prev_x_r <= x;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= $signed({1'b0, alpha}) * sum_r;
          state_r <= S_FILT;
        end
        S_FILT: begin
          y_r     <= y_nxt;
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          g_r     <= g_full[GAIN_W-1:0];
          state_r <= S_DSTART;
        end
        S_DSTART: begin
          neg_r   <= g_r[GAIN_W-1];
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_stat.done) begin
            sample_r <= sample_nxt;
            done_r   <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign sample = sample_r;

endmodule

@@ rtl/core/oversampled_pulse_synth_highpass.sv @@
// Top level of the oversampled pulse synth with DC-blocking high-pass.
// One input transaction is one output-sample tick and yields exactly one
// result transaction. For an active tick the phase increment and the duty
// threshold come from two bit-serial dividers by constants that run side by
// side, the phase accumulator then makes one oversampling step per cycle,
// and the output gain is a bit-serial divide. An inactive tick skips the
// oscillator's dividers and phase steps. One tick is in flight at a time; a
// finished sample waits in the output register and the next tick is taken
// meanwhile. highpass_alpha sits at APB byte address 0 and reads back.
module oversampled_pulse_synth_highpass #(
  parameter int LEVEL_MAX         = 255,
  parameter int OVERSAMPLE_FACTOR = 8,
  parameter int SAMPLE_RATE       = 48000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  opsh_in_if.sink                           in_chan,
  opsh_out_if.source                        out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [opsh_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [opsh_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [opsh_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import opsh_pkg::*;

  localparam int CNT_W = $clog2(OVERSAMPLE_FACTOR + 1);

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_LOAD} state_t;

  state_t              state_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [ALPHA_W-1:0]  alpha_r;
  logic                accept, slot_free, cfg_wr;
  logic                osc_done, hpf_done;
  logic [CNT_W-1:0]    count;
  logic [SAMPLE_W-1:0] hpf_sample;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  opsh_osc #(
    .LEVEL_MAX         (LEVEL_MAX),
    .OVERSAMPLE_FACTOR (OVERSAMPLE_FACTOR),
    .SAMPLE_RATE       (SAMPLE_RATE),
    .CNT_W             (CNT_W)
  ) u_osc (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .active     (in_chan.active),
    .tone_freq  (in_chan.tone_freq),
    .duty_level (in_chan.duty_level),
    .done       (osc_done),
    .count      (count)
  );

  opsh_hpf #(
    .OVERSAMPLE_FACTOR (OVERSAMPLE_FACTOR),
    .CNT_W             (CNT_W)
  ) u_hpf (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (osc_done),
    .count  (count),
    .alpha  (alpha_r),
    .done   (hpf_done),
    .sample (hpf_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_LOAD) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (hpf_done) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (slot_free) begin
            out_sample_r <= hpf_sample;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = out_sample_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_ADDR_W-1] == REG_HIGHPASS_ALPHA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_wr) begin
      alpha_r <= cfg_pwdata[ALPHA_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_HIGHPASS_ALPHA)
                      ? {{(CFG_DATA_W - ALPHA_W){1'b0}}, alpha_r} : '0;

endmodule

@@ rtl/core/opsh_chk.sv @@
// Port-level assertion checker for the pulse synth, bound to the top level.
`include "oversampled_pulse_synth_highpass_macros.svh"

module opsh_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [opsh_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input logic [opsh_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input logic [opsh_pkg::CFG_DATA_W-1:0]   cfg_prdata
);
  import opsh_pkg::*;

  logic in_acc, alpha_wr, alpha_rd;

  assign in_acc   = in_valid && in_ready;
  assign alpha_wr = cfg_psel && cfg_penable && cfg_pwrite
                    && (cfg_paddr[CFG_ADDR_W-1] == REG_HIGHPASS_ALPHA);
  assign alpha_rd = cfg_psel && !cfg_pwrite
                    && (cfg_paddr[CFG_ADDR_W-1] == REG_HIGHPASS_ALPHA);

  `OPSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `OPSH_ASSERT_NEXT(a_busy_after_acc, in_acc, !in_ready, "transaction taken while busy")
  `OPSH_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(out_valid), "result too early")
  `OPSH_ASSERT_NEXT(a_alpha_readback, alpha_wr, !alpha_rd || (cfg_prdata == {{(CFG_DATA_W - ALPHA_W){1'b0}}, $past(cfg_pwdata[ALPHA_W-1:0])}), "alpha readback mismatch")

endmodule

bind oversampled_pulse_synth_highpass opsh_chk u_opsh_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
